/* sv/lcpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpm_pkg
// Shared widths, register indexes, reset values and helpers for the lane
// color pixel mask.
// ----------------------------------------------------------------------------
package lcpm_pkg;

  // channel and register widths
  localparam int unsigned CH_W    = 8;
  localparam int unsigned REG_W   = 24;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned IN_W    = 3 * CH_W;
  localparam int unsigned OUT_W   = 32;

  // reciprocal table: entry d holds floor(2^RECIP_SHIFT / d), entry 0 holds 0
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_DEPTH = 256;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

  // hue range of the 8-bit hsv form
  localparam logic [CH_W:0] HUE_WRAP = 9'd180;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_WHITE_LOW   = 3'd0,
    REG_WHITE_HIGH  = 3'd1,
    REG_YELLOW_LOW  = 3'd2,
    REG_YELLOW_HIGH = 3'd3,
    REG_BLUE_LOW    = 3'd4,
    REG_BLUE_HIGH   = 3'd5
  } reg_idx_t;

  // register reset values
  localparam logic [REG_W-1:0] WHITE_LOW_RST   = 24'h969696;
  localparam logic [REG_W-1:0] WHITE_HIGH_RST  = 24'hFFFFFF;
  localparam logic [REG_W-1:0] YELLOW_LOW_RST  = 24'h64640A;
  localparam logic [REG_W-1:0] YELLOW_HIGH_RST = 24'hFFFF28;
  localparam logic [REG_W-1:0] BLUE_LOW_RST    = 24'h322850;
  localparam logic [REG_W-1:0] BLUE_HIGH_RST   = 24'h966482;

  // inclusive three-channel range check against packed bounds
  function automatic logic box_hit(input logic [CH_W-1:0]  a0,
                                   input logic [CH_W-1:0]  a1,
                                   input logic [CH_W-1:0]  a2,
                                   input logic [REG_W-1:0] lo,
                                   input logic [REG_W-1:0] hi);
    box_hit = (a0 >= lo[7:0])   && (a0 <= hi[7:0])   &&
              (a1 >= lo[15:8])  && (a1 <= hi[15:8])  &&
              (a2 >= lo[23:16]) && (a2 <= hi[23:16]);
  endfunction

  // channel times match count, clipped to the channel range
  function automatic logic [CH_W-1:0] scale_sat(input logic [CH_W-1:0] ch,
                                                input logic [1:0]      n);
    logic [CH_W+1:0] prod;
    prod = {2'b00, ch} * {{CH_W{1'b0}}, n};
    scale_sat = (prod > {2'b00, {CH_W{1'b1}}}) ? {CH_W{1'b1}} : prod[CH_W-1:0];
  endfunction

endpackage

/* sv/lane_color_pixel_mask.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_color_pixel_mask
// Per-pixel white bgr and yellow/blue hsv range test, output channels scaled
// by the number of matching ranges.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the output is not stalled, set by the
//   five-stage pipeline with a shared stall enable (divides use a reciprocal
//   table, multiply, correct)
// reset: rst_n synchronous active low, clears all valid bits and loads the
//   range registers with their default bounds; no clearing pass
module lane_color_pixel_mask (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lcpm_pkg::IN_W-1:0]     in_tdata,   // in_blue, in_green, in_red
  // output stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lcpm_pkg::OUT_W-1:0]    out_tdata,  // out_blue, out_green,
                                                    // out_red, white_hit,
                                                    // yellow_hit, blue_hit, pad
  // configuration
  input  logic                          cfg_we,
  input  logic [lcpm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lcpm_pkg::REG_W-1:0]    cfg_wdata
);

  localparam int unsigned CW = lcpm_pkg::CH_W;
  localparam int unsigned RW = lcpm_pkg::RECIP_W;
  localparam int unsigned RS = lcpm_pkg::RECIP_SHIFT;

  // range registers
  logic [lcpm_pkg::REG_W-1:0] white_low_r, white_high_r;
  logic [lcpm_pkg::REG_W-1:0] yellow_low_r, yellow_high_r;
  logic [lcpm_pkg::REG_W-1:0] blue_low_r, blue_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_low_r   <= lcpm_pkg::WHITE_LOW_RST;
      white_high_r  <= lcpm_pkg::WHITE_HIGH_RST;
      yellow_low_r  <= lcpm_pkg::YELLOW_LOW_RST;
      yellow_high_r <= lcpm_pkg::YELLOW_HIGH_RST;
      blue_low_r    <= lcpm_pkg::BLUE_LOW_RST;
      blue_high_r   <= lcpm_pkg::BLUE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcpm_pkg::REG_WHITE_LOW:   white_low_r   <= cfg_wdata;
        lcpm_pkg::REG_WHITE_HIGH:  white_high_r  <= cfg_wdata;
        lcpm_pkg::REG_YELLOW_LOW:  yellow_low_r  <= cfg_wdata;
        lcpm_pkg::REG_YELLOW_HIGH: yellow_high_r <= cfg_wdata;
        lcpm_pkg::REG_BLUE_LOW:    blue_low_r    <= cfg_wdata;
        lcpm_pkg::REG_BLUE_HIGH:   blue_high_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // reciprocal table, one constant entry per divisor
  logic [RW-1:0] recip_tab [lcpm_pkg::RECIP_DEPTH];

  assign recip_tab[0] = '0;
  for (genvar Div = 1; Div < lcpm_pkg::RECIP_DEPTH; Div++) begin : g_recip
    localparam int unsigned RecipVal = (1 << RS) / Div;
    assign recip_tab[Div] = RW'(RecipVal);
  end

  // pipeline advance: every stage moves unless the output word is stuck
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage a: max, min, hue sector, white test ----------------
  logic [CW-1:0] in_b, in_g, in_r;
  logic [CW-1:0] mx_c, mn_c, diff_c;
  logic [10:0]   x_c;

  assign in_b = in_tdata[7:0];
  assign in_g = in_tdata[15:8];
  assign in_r = in_tdata[23:16];

  always_comb begin
    mx_c = in_r;
    if (in_g > mx_c) mx_c = in_g;
    if (in_b > mx_c) mx_c = in_b;
    mn_c = in_r;
    if (in_g < mn_c) mn_c = in_g;
    if (in_b < mn_c) mn_c = in_b;
    diff_c = mx_c - mn_c;
    // hue in sixths of a turn times diff, red preferred on ties, then green
    if (mx_c == in_r) begin
      if (in_g >= in_b) x_c = {3'b000, in_g - in_b};
      else              x_c = 11'(6 * {3'b000, diff_c}) - {3'b000, in_b - in_g};
    end else if (mx_c == in_g) begin
      x_c = {2'b00, diff_c, 1'b0} + {3'b000, in_b} - {3'b000, in_r};
    end else begin
      x_c = {1'b0, diff_c, 2'b00} + {3'b000, in_r} - {3'b000, in_g};
    end
  end

  logic          a_vld_r;
  logic [CW-1:0] a_b_r, a_g_r, a_r_r, a_mx_r, a_diff_r;
  logic [10:0]   a_x_r;
  logic          a_wh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_b_r    <= in_b;
      a_g_r    <= in_g;
      a_r_r    <= in_r;
      a_mx_r   <= mx_c;
      a_diff_r <= diff_c;
      a_x_r    <= x_c;
      a_wh_r   <= lcpm_pkg::box_hit(in_b, in_g, in_r, white_low_r, white_high_r);
    end
  end

  // ---------------- stage b: dividends and reciprocal lookup ----------------
  logic [15:0] ns_c;
  logic [16:0] nh_c;

  // 255*diff + mx/2 and 60*x + diff
  assign ns_c = {a_diff_r, 8'h00} - {8'h00, a_diff_r} + {9'h000, a_mx_r[7:1]};
  assign nh_c = {a_x_r, 6'b000000} - {4'h0, a_x_r, 2'b00} + {9'h000, a_diff_r};

  logic          b_vld_r;
  logic [CW-1:0] b_b_r, b_g_r, b_r_r, b_mx_r, b_diff_r;
  logic [15:0]   b_ns_r;
  logic [16:0]   b_nh_r;
  logic [RW-1:0] b_rs_r, b_rh_r;
  logic          b_wh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_b_r    <= a_b_r;
      b_g_r    <= a_g_r;
      b_r_r    <= a_r_r;
      b_mx_r   <= a_mx_r;
      b_diff_r <= a_diff_r;
      b_ns_r   <= ns_c;
      b_nh_r   <= nh_c;
      b_rs_r   <= recip_tab[a_mx_r];
      b_rh_r   <= recip_tab[a_diff_r];
      b_wh_r   <= a_wh_r;
    end
  end

  // ---------------- stage c: quotient estimates ----------------
  // estimate is the true quotient or one below it
  logic [32:0] ps_c;
  logic [33:0] ph_c;

  assign ps_c = {17'h00000, b_ns_r} * {16'h0000, b_rs_r};
  assign ph_c = {17'h00000, b_nh_r} * {17'h00000, b_rh_r};

  logic          c_vld_r;
  logic [CW-1:0] c_b_r, c_g_r, c_r_r, c_mx_r, c_diff_r;
  logic [15:0]   c_ns_r;
  logic [16:0]   c_nh_r;
  logic [CW-1:0] c_qs_r, c_qh_r;
  logic          c_wh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (en) c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_b_r    <= b_b_r;
      c_g_r    <= b_g_r;
      c_r_r    <= b_r_r;
      c_mx_r   <= b_mx_r;
      c_diff_r <= b_diff_r;
      c_ns_r   <= b_ns_r;
      c_nh_r   <= b_nh_r;
      c_qs_r   <= ps_c[RS+CW-1:RS];
      c_qh_r   <= ph_c[RS+CW:RS+1];
      c_wh_r   <= b_wh_r;
    end
  end

  // ---------------- stage d: quotient correction, hue wrap ----------------
  logic [CW:0]   dh_c;
  logic [15:0]   bs_c, rems_c;
  logic [16:0]   bh_c, remh_c;
  logic [CW:0]   sq_c, hq_c, hw_c;

  always_comb begin
    dh_c   = {c_diff_r, 1'b0};
    bs_c   = {8'h00, c_qs_r} * {8'h00, c_mx_r};
    bh_c   = {9'h000, c_qh_r} * {8'h00, dh_c};
    rems_c = c_ns_r - bs_c;
    remh_c = c_nh_r - bh_c;
    // black pixels have zero divisors, grey pixels a zero hue divisor; both get zero here
    sq_c = {1'b0, c_qs_r} +
           {{CW{1'b0}}, (rems_c >= {8'h00, c_mx_r}) && (c_mx_r != '0)};
    hq_c = {1'b0, c_qh_r} +
           {{CW{1'b0}}, (remh_c >= {8'h00, dh_c}) && (c_diff_r != '0)};
    hw_c = (hq_c >= lcpm_pkg::HUE_WRAP) ? hq_c - lcpm_pkg::HUE_WRAP : hq_c;
  end

  logic          d_vld_r;
  logic [CW-1:0] d_b_r, d_g_r, d_r_r;
  logic [CW-1:0] d_h_r, d_s_r, d_v_r;
  logic          d_gray_r;
  logic          d_wh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (en) d_vld_r <= c_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_b_r    <= c_b_r;
      d_g_r    <= c_g_r;
      d_r_r    <= c_r_r;
      d_h_r    <= hw_c[CW-1:0];
      d_s_r    <= sq_c[CW-1:0];
      d_v_r    <= c_mx_r;
      d_gray_r <= (c_diff_r == '0);
      d_wh_r   <= c_wh_r;
    end
  end

  // ---------------- stage e: hsv range tests, scaling, output word ----------------
  logic       ye_c, bl_c;
  logic [1:0] n_c;

  assign ye_c = lcpm_pkg::box_hit(d_h_r, d_s_r, d_v_r, yellow_low_r, yellow_high_r);
  assign bl_c = lcpm_pkg::box_hit(d_h_r, d_s_r, d_v_r, blue_low_r, blue_high_r);
  assign n_c  = {1'b0, d_wh_r} + {1'b0, ye_c} + {1'b0, bl_c};

  logic                       out_vld_r;
  logic [lcpm_pkg::OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= d_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {5'b00000, bl_c, ye_c, d_wh_r,
                     lcpm_pkg::scale_sat(d_r_r, n_c),
                     lcpm_pkg::scale_sat(d_g_r, n_c),
                     lcpm_pkg::scale_sat(d_b_r, n_c)};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  // corrected hue always lands inside the 8-bit hue range
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> (d_h_r < lcpm_pkg::HUE_WRAP[CW-1:0]))
    else $error("hue out of range");

  // grey pixels carry zero hue and zero saturation
  a_gray_hsv: assert property (@(posedge clk) disable iff (!rst_n)
    (d_vld_r && d_gray_r) |-> (d_h_r == '0 && d_s_r == '0))
    else $error("grey pixel with nonzero hue or saturation");

  // no match means a black output pixel
  a_no_hit_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[26:24] == 3'b000) |-> (out_tdata[23:0] == '0))
    else $error("unmatched pixel with nonzero channels");

  // a stalled pipeline keeps all its valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({a_vld_r, b_vld_r, c_vld_r, d_vld_r, out_vld_r}))
    else $error("valid bit changed during stall");

endmodule

/* verif/lane_color_pixel_mask_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_color_pixel_mask_tb
// Streams bgr pixels through the lane color mask and checks every output
// word against a local predictor of the white bgr and yellow/blue hsv range
// tests. Range registers are rewritten between phases (reset defaults, fully
// open, fully inverted, random). Sender and receiver stall at random, with
// one long receiver hold-off and drained pauses between chunks.
// ----------------------------------------------------------------------------
module lane_color_pixel_mask_tb;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_LIMIT    = 4000;
  localparam int unsigned PIPE_DRAIN     = 12;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned HUE_SPAN       = 180;

  // indexes outside the register map, writes there must be ignored
  localparam logic [lcpm_pkg::IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [lcpm_pkg::IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;

  typedef struct packed {
    logic [lcpm_pkg::CH_W-1:0] red;
    logic [lcpm_pkg::CH_W-1:0] green;
    logic [lcpm_pkg::CH_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic [lcpm_pkg::CH_W-1:0] blue;
    logic [lcpm_pkg::CH_W-1:0] green;
    logic [lcpm_pkg::CH_W-1:0] red;
    logic                      white_hit;
    logic                      yellow_hit;
    logic                      blue_hit;
  } mask_word_t;

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_tvalid   = 1'b0;
  logic                         in_tready;
  logic [lcpm_pkg::IN_W-1:0]    in_tdata    = '0;   // in_blue, in_green, in_red
  logic                         out_tvalid;
  logic                         out_tready  = 1'b0;
  logic [lcpm_pkg::OUT_W-1:0]   out_tdata;          // out_blue, out_green, out_red,
                                                    // white_hit, yellow_hit,
                                                    // blue_hit, pad
  logic                         cfg_we      = 1'b0;
  logic [lcpm_pkg::IDX_W-1:0]   cfg_index   = '0;
  logic [lcpm_pkg::REG_W-1:0]   cfg_wdata   = '0;

  // local copy of the range registers
  logic [lcpm_pkg::REG_W-1:0]   range_reg [0:5];

  pixel_t            pixel_q [$];
  mask_word_t        mask_q  [$];

  int unsigned       tx_idle_pct  = 27;
  int unsigned       rx_idle_pct  = 83;
  logic              rx_hold_req  = 1'b0;
  int unsigned       rx_hold_left = 0;
  int unsigned       cycle_cnt    = 0;
  int unsigned       err_cnt      = 0;

  lane_color_pixel_mask dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // inclusive check of three bytes against packed low/high bounds
  function automatic logic within_bounds(input int unsigned a0, input int unsigned a1,
                                         input int unsigned a2,
                                         input logic [lcpm_pkg::REG_W-1:0] lo,
                                         input logic [lcpm_pkg::REG_W-1:0] hi);
    return a0 >= lo[7:0]   && a0 <= hi[7:0]   &&
           a1 >= lo[15:8]  && a1 <= hi[15:8]  &&
           a2 >= lo[23:16] && a2 <= hi[23:16];
  endfunction

  function automatic logic [lcpm_pkg::CH_W-1:0] clip_scale(input int unsigned ch,
                                                           input int unsigned n);
    int unsigned p;
    p = ch * n;
    return (p > 255) ? 8'hFF : p[lcpm_pkg::CH_W-1:0];
  endfunction

  // expected output word for one pixel under the current ranges
  function automatic mask_word_t predict_mask(input pixel_t px);
    int unsigned b, g, r, top, bottom, diff, sixths, hue, sat, hits;
    mask_word_t m;
    b = px.blue;
    g = px.green;
    r = px.red;
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    diff = top - bottom;
    sat = (top == 0) ? 0 : (diff * 255 + top / 2) / top;
    // hue in halved degrees, red wins a tie for maximum, then green
    if (diff == 0) begin
      hue = 0;
    end else begin
      if (top == r) begin
        sixths = (g >= b) ? (g - b) : (6 * diff - (b - g));
      end else if (top == g) begin
        sixths = 2 * diff + b - r;
      end else begin
        sixths = 4 * diff + r - g;
      end
      hue = (60 * sixths + diff) / (2 * diff);
      if (hue >= HUE_SPAN) hue = hue - HUE_SPAN;
    end
    m.white_hit  = within_bounds(b, g, r, range_reg[lcpm_pkg::REG_WHITE_LOW],
                                 range_reg[lcpm_pkg::REG_WHITE_HIGH]);
    m.yellow_hit = within_bounds(hue, sat, top, range_reg[lcpm_pkg::REG_YELLOW_LOW],
                                 range_reg[lcpm_pkg::REG_YELLOW_HIGH]);
    m.blue_hit   = within_bounds(hue, sat, top, range_reg[lcpm_pkg::REG_BLUE_LOW],
                                 range_reg[lcpm_pkg::REG_BLUE_HIGH]);
    hits = m.white_hit + m.yellow_hit + m.blue_hit;
    m.blue  = clip_scale(b, hits);
    m.green = clip_scale(g, hits);
    m.red   = clip_scale(r, hits);
    return m;
  endfunction

  // driver: offers pending pixels, records the expected word on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) mask_q = {mask_q, predict_mask(pixel_t'(in_tdata))};
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // monitor: compares each accepted word with the oldest expectation
  always @(posedge clk) begin : monitor
    mask_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (mask_q.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, 0);
        end else begin
          want = mask_q.pop_front();
          if (out_tdata[7:0] !== want.blue)
            report_mismatch("out_blue", out_tdata[7:0], want.blue);
          if (out_tdata[15:8] !== want.green)
            report_mismatch("out_green", out_tdata[15:8], want.green);
          if (out_tdata[23:16] !== want.red)
            report_mismatch("out_red", out_tdata[23:16], want.red);
          if (out_tdata[24] !== want.white_hit)
            report_mismatch("white_hit", out_tdata[24], want.white_hit);
          if (out_tdata[25] !== want.yellow_hit)
            report_mismatch("yellow_hit", out_tdata[25], want.yellow_hit);
          if (out_tdata[26] !== want.blue_hit)
            report_mismatch("blue_hit", out_tdata[26], want.blue_hit);
        end
      end
      out_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_pixel(input int unsigned b, input int unsigned g,
                           input int unsigned r);
    pixel_t px;
    px.blue  = b[7:0];
    px.green = g[7:0];
    px.red   = r[7:0];
    pixel_q = {pixel_q, px};
  endtask

  // mix of random, near-grey, two-equal-channel and bright pixels
  task automatic add_random_pixels(input int unsigned count);
    int unsigned b, g, r;
    for (int unsigned i = 0; i < count; i++) begin
      b = $urandom_range(255);
      g = $urandom_range(255);
      r = $urandom_range(255);
      case ($urandom_range(4))
        1: begin
          g = (r + $urandom_range(4)) & 8'hFF;
          b = (r + $urandom_range(4)) & 8'hFF;
        end
        2: begin
          case ($urandom_range(2))
            0: g = r;
            1: b = r;
            default: b = g;
          endcase
        end
        3: begin
          b = $urandom_range(150, 255);
          g = $urandom_range(150, 255);
          r = $urandom_range(150, 255);
        end
        default: ;
      endcase
      add_pixel(b, g, r);
    end
  endtask

  // wait until every pixel went in and every word came out
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while ((pixel_q.size() != 0 || in_tvalid || mask_q.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_DRAIN) @(posedge clk);
    if (mask_q.size() != 0) begin
      report_mismatch("words never delivered", 0, mask_q.size());
      mask_q.delete();
    end
  endtask

  task automatic write_reg(input logic [lcpm_pkg::IDX_W-1:0] idx,
                           input logic [lcpm_pkg::REG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx <= lcpm_pkg::REG_BLUE_HIGH) range_reg[idx] = val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_ranges(input logic [lcpm_pkg::REG_W-1:0] wl,
                             input logic [lcpm_pkg::REG_W-1:0] wh,
                             input logic [lcpm_pkg::REG_W-1:0] yl,
                             input logic [lcpm_pkg::REG_W-1:0] yh,
                             input logic [lcpm_pkg::REG_W-1:0] bl,
                             input logic [lcpm_pkg::REG_W-1:0] bh);
    write_reg(lcpm_pkg::REG_WHITE_LOW, wl);
    write_reg(lcpm_pkg::REG_WHITE_HIGH, wh);
    write_reg(lcpm_pkg::REG_YELLOW_LOW, yl);
    write_reg(lcpm_pkg::REG_YELLOW_HIGH, yh);
    write_reg(lcpm_pkg::REG_BLUE_LOW, bl);
    write_reg(lcpm_pkg::REG_BLUE_HIGH, bh);
  endtask

  // random bounds, now and then inverted or collapsed to a single value
  function automatic void random_bounds(output logic [lcpm_pkg::REG_W-1:0] lo,
                                        output logic [lcpm_pkg::REG_W-1:0] hi);
    int unsigned l, h;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(9))
        0: begin
          l = $urandom_range(1, 255);
          h = $urandom_range(0, l - 1);
        end
        1: begin
          l = $urandom_range(255);
          h = l;
        end
        default: begin
          l = $urandom_range(0, 100);
          h = $urandom_range(l, 255);
        end
      endcase
      lo[8*k +: 8] = l[7:0];
      hi[8*k +: 8] = h[7:0];
    end
  endfunction

  task automatic load_random_ranges();
    logic [lcpm_pkg::REG_W-1:0] wl, wh, yl, yh, bl, bh;
    random_bounds(wl, wh);
    random_bounds(yl, yh);
    random_bounds(bl, bh);
    load_ranges(wl, wh, yl, yh, bl, bh);
  endtask

  initial begin
    range_reg[lcpm_pkg::REG_WHITE_LOW]   = lcpm_pkg::WHITE_LOW_RST;
    range_reg[lcpm_pkg::REG_WHITE_HIGH]  = lcpm_pkg::WHITE_HIGH_RST;
    range_reg[lcpm_pkg::REG_YELLOW_LOW]  = lcpm_pkg::YELLOW_LOW_RST;
    range_reg[lcpm_pkg::REG_YELLOW_HIGH] = lcpm_pkg::YELLOW_HIGH_RST;
    range_reg[lcpm_pkg::REG_BLUE_LOW]    = lcpm_pkg::BLUE_LOW_RST;
    range_reg[lcpm_pkg::REG_BLUE_HIGH]   = lcpm_pkg::BLUE_HIGH_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels under the default ranges (b, g, r)
    tx_idle_pct = 27;
    rx_idle_pct = 83;
    add_pixel(0, 0, 0);          // black
    add_pixel(255, 255, 255);    // full white
    add_pixel(128, 128, 128);    // grey
    add_pixel(150, 150, 150);    // white lower edge
    add_pixel(149, 150, 150);    // just below white
    add_pixel(0, 0, 255);        // pure red
    add_pixel(0, 255, 0);        // pure green
    add_pixel(255, 0, 0);        // pure blue
    add_pixel(0, 255, 255);      // red and green share maximum
    add_pixel(255, 255, 0);      // green and blue share maximum
    add_pixel(255, 0, 255);      // red and blue share maximum
    add_pixel(1, 0, 255);        // hue rounds up to the wrap point
    add_pixel(0, 1, 255);
    add_pixel(150, 255, 255);    // white and yellow, clipped channels
    add_pixel(150, 120, 100);    // blue range
    add_pixel(255, 100, 0);
    add_pixel(0, 0, 1);          // darkest colored pixel
    add_pixel(1, 0, 0);
    add_pixel(255, 254, 255);
    add_pixel(10, 100, 200);
    add_pixel(200, 100, 10);
    add_pixel(0, 200, 200);      // yellow hue
    settle();

    // random, in two chunks with a drained pause between
    add_random_pixels(125);
    settle();
    add_random_pixels(125);
    settle();

    // fully open ranges; unmapped writes would close yellow if aliased
    load_ranges(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                24'h000000, 24'hFFFFFF);
    write_reg(REG_UNMAPPED_6, 24'hFFFFFF);
    write_reg(REG_UNMAPPED_7, 24'h000000);
    add_random_pixels(150);
    settle();

    // fully inverted ranges, nothing matches
    tx_idle_pct = 83;
    rx_idle_pct = 27;
    load_ranges(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000,
                24'hFFFFFF, 24'h000000);
    add_random_pixels(100);
    settle();

    load_random_ranges();
    add_random_pixels(130);
    settle();

    // no idling; long receiver hold-off fills the pipeline
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_random_ranges();
    add_random_pixels(130);
    @(posedge clk);
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
    settle();

    load_random_ranges();
    add_random_pixels(130);
    settle();

    load_random_ranges();
    add_random_pixels(130);
    settle();

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lcpm_pkg.sv
sv/lane_color_pixel_mask.sv
verif/lane_color_pixel_mask_tb.sv
